// File: rtl/assert_macros.svh
// Assertion macros for the RTL files; clocked on clk, quiet during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mru_pkg.sv
// Types and constants for the MRU page replacement block.
`default_nettype none

package mru_pkg;

  localparam int PAGE_W     = 16;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 32;
  localparam int CFG_W      = 5;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  // register index, taken from paddr word bits
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              last_access;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [SLOT_W-1:0]  frame_slot;
    logic [COUNT_W-1:0] fault_count;
    logic [COUNT_W-1:0] access_count;
    logic               run_end;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/mru_apb_regs.sv
// APB configuration register file: frame limit register and readback.
`default_nettype none

module mru_apb_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mru_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [mru_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [mru_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output logic      [mru_pkg::CFG_W-1:0]       frames_in_use
);
  import mru_pkg::*;

  logic reg_idx;
  logic wr_en;

  // word index; byte offset bits ignored
  assign reg_idx = paddr[APB_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_IN_USE_RESET;
    end else if (wr_en && reg_idx == REG_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAMES_IN_USE: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, frames_in_use};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mru_page_replacement.sv
// MRU page replacement: fully associative frame table scanned by one comparator.
//
// Access channel (access_valid/access_stall/access) carries one page reference
// per beat; the result channel (result_valid/result_stall/result) returns one
// beat per access with hit/fault, evicted page, slot and running counts.
// One access at a time: after a beat is taken, a sequencer reads the frame
// store one entry per cycle through a single compare unit (the read port is
// registered, so the compare runs one entry behind), then a commit step
// updates the table and loads the output register. A new access is taken the
// cycle after commit; result_valid is registered from commit.
// The output register holds a result while result_stall is high; a next
// access is still taken and scanned, and waits in the commit step until the
// output register frees up. An access with last_access set ends the run: the
// table and counters clear as its result is loaded.
// Reset clears all valid bits, counters and the frame limit (to 16) and holds
// access_stall high; frame contents need no clearing. frames_in_use is set over
// the APB port at offset 0; 0 acts as 1, above FRAMES as FRAMES. The user must
// write it only while idle; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module mru_page_replacement #(
  parameter int FRAMES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mru_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [mru_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [mru_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  input  wire logic                            access_valid,
  output logic                                 access_stall,
  input  wire mru_pkg::in_t                    access,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output mru_pkg::out_t                        result
);
  import mru_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LIM_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  state_t state, state_next;

  logic [CFG_W-1:0]   frames_in_use;

  // frame store
  logic [PAGE_W-1:0]  frame_page [FRAMES];
  logic [PAGE_W-1:0]  rd_data;
  logic [FRAMES-1:0]  frame_valid;

  // run state
  logic [IDX_W-1:0]   recent_frame;
  logic [CNT_W-1:0]   filled_count;
  logic [COUNT_W-1:0] faults;
  logic [COUNT_W-1:0] accesses;

  // per-access scan registers
  logic [PAGE_W-1:0]  page;
  logic               last;
  logic [CNT_W-1:0]   idx;
  logic               cmp_en;
  logic [IDX_W-1:0]   cmp_idx;
  logic               found;
  logic [IDX_W-1:0]   match_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [PAGE_W-1:0]  evict_page;

  logic               accept;
  logic               scan_live;
  logic [IDX_W-1:0]   scan_addr;
  logic               commit;

  logic [LIM_W-1:0]   cfg_ext;
  logic [LIM_W-1:0]   limit;
  logic               fill_ok;
  logic               use_free;
  logic [IDX_W-1:0]   slot;
  logic               fill_new;
  logic               evict;
  logic [COUNT_W-1:0] faults_next;
  logic [COUNT_W-1:0] accesses_next;
  logic [IDX_W+SLOT_W-1:0] slot_wide;

  mru_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frames_in_use (frames_in_use)
  );

  assign accept    = access_valid && !access_stall;
  assign scan_live = idx < CNT_W'(FRAMES);
  assign scan_addr = idx[IDX_W-1:0];
  assign commit    = (state == ST_FINISH) && (!result_valid || !result_stall);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    access_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        access_stall = rst;
        if (access_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_live) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- replacement decision ----------------
  always_comb begin
    cfg_ext = LIM_W'(frames_in_use);
    if (cfg_ext == '0) begin
      limit = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(FRAMES)) begin
      limit = LIM_W'(FRAMES);
    end else begin
      limit = cfg_ext;
    end
    fill_ok  = LIM_W'(filled_count) < limit;
    use_free = fill_ok && free_found;
    if (found) begin
      slot = match_idx;
    end else if (use_free) begin
      slot = free_idx;
    end else begin
      slot = recent_frame;
    end
    // a fault claims a new frame when it takes a free one or the MRU slot is empty
    fill_new = !found && (use_free || !frame_valid[slot]);
    evict    = !found && !fill_new;

    accesses_next = (accesses == '1) ? accesses : accesses + COUNT_W'(1);
    if (!found && faults != '1) begin
      faults_next = faults + COUNT_W'(1);
    end else begin
      faults_next = faults;
    end
    slot_wide = {{SLOT_W{1'b0}}, slot};
  end

  // ---------------- frame store ----------------
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && scan_live) begin
      rd_data <= frame_page[scan_addr];
    end
    if (commit && !found) begin
      frame_page[slot] <= page;
    end
  end

  // ---------------- scan datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= (state == ST_SCAN) && scan_live;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page       <= access.page_number;
      last       <= access.last_access;
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      cmp_idx <= scan_addr;
      if (scan_live) begin
        idx <= idx + CNT_W'(1);
        if (!free_found && !frame_valid[scan_addr]) begin
          free_found <= 1'b1;
          free_idx   <= scan_addr;
        end
      end
      // compare stage, one entry behind the read address
      if (cmp_en) begin
        if (!found && frame_valid[cmp_idx] && rd_data == page) begin
          found     <= 1'b1;
          match_idx <= cmp_idx;
        end
        if (cmp_idx == recent_frame) begin
          evict_page <= rd_data;
        end
      end
    end
  end

  // ---------------- run state and output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid  <= '0;
      recent_frame <= '0;
      filled_count <= '0;
      faults       <= '0;
      accesses     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (commit) begin
        result_valid <= 1'b1;
        if (last) begin
          frame_valid  <= '0;
          recent_frame <= '0;
          filled_count <= '0;
          faults       <= '0;
          accesses     <= '0;
        end else begin
          if (fill_new) begin
            frame_valid[slot] <= 1'b1;
            filled_count      <= filled_count + CNT_W'(1);
          end
          recent_frame <= slot;
          faults       <= faults_next;
          accesses     <= accesses_next;
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.hit           <= found;
      result.evicted_valid <= evict;
      result.evicted_page  <= evict ? evict_page : '0;
      result.frame_slot    <= slot_wide[SLOT_W-1:0];
      result.fault_count   <= faults_next;
      result.access_count  <= accesses_next;
      result.run_end       <= last;
    end
  end

  // ---------------- checks ----------------
  `ASSERT_ALWAYS(a_fill_bound, filled_count <= CNT_W'(FRAMES), "filled_count above FRAMES")
  `ASSERT_ALWAYS(a_fill_tracks_valid, int'(filled_count) == $countones(frame_valid),
                 "filled_count out of step with valid bits")
  `ASSERT_ALWAYS(a_hit_no_evict, !(result_valid && result.hit && result.evicted_valid),
                 "hit reported with eviction")
  `ASSERT_NEXT(a_run_end_clears, commit && last, filled_count == '0 && accesses == '0,
               "run state not cleared after last access")

endmodule

`default_nettype wire

// File: tb/mru_page_replacement_tb.sv
// Testbench for mru_page_replacement: directed and random page traces checked beat by beat.
`timescale 1ns / 100ps

module mru_page_replacement_tb;
  import mru_pkg::*;

  localparam int FRAMES      = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = FRAMES + 8;
  localparam logic [APB_ADDR_W-1:0] FRAMES_IN_USE_ADDR = {REG_FRAMES_IN_USE, 2'b00};

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic access_valid;
  logic access_stall;
  in_t  access;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;

  mru_page_replacement #(.FRAMES(FRAMES)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .access_valid (access_valid),
    .access_stall (access_stall),
    .access       (access),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the frame table and run counters
  logic [PAGE_W-1:0]  tbl_page [FRAMES];
  logic               tbl_valid [FRAMES];
  logic [SLOT_W-1:0]  mru_slot;
  int                 filled;
  logic [COUNT_W-1:0] fault_tally;
  logic [COUNT_W-1:0] access_tally;
  logic [CFG_W-1:0]   frame_limit;

  out_t expected_results[$];
  int   mismatches = 0;
  int   cycle_count = 0;

  bit sender_gaps  = 1'b1;
  bit stall_random = 1'b1;
  int hold_request = 0;

  function automatic void clear_table();
    for (int idx = 0; idx < FRAMES; idx++) begin
      tbl_valid[idx] = 1'b0;
      tbl_page[idx]  = '0;
    end
    mru_slot     = '0;
    filled       = 0;
    fault_tally  = '0;
    access_tally = '0;
  endfunction

  function automatic out_t predict_access(in_t item);
    out_t r;
    int   lim;
    bit   found;
    bit   got_free;
    logic [SLOT_W-1:0] slot;
    r = '0;
    lim = int'(frame_limit);
    if (lim < 1) lim = 1;
    if (lim > FRAMES) lim = FRAMES;
    found = 1'b0;
    slot  = '0;
    for (int idx = 0; idx < FRAMES; idx++) begin
      if (!found && tbl_valid[idx] && tbl_page[idx] == item.page_number) begin
        found = 1'b1;
        slot  = idx[SLOT_W-1:0];
      end
    end
    access_tally += COUNT_W'(access_tally != '1);
    if (found) begin
      r.hit = 1'b1;
    end else begin
      fault_tally += COUNT_W'(fault_tally != '1);
      if (filled < lim) begin
        got_free = 1'b0;
        for (int idx = 0; idx < FRAMES; idx++) begin
          if (!got_free && !tbl_valid[idx]) begin
            got_free = 1'b1;
            slot     = idx[SLOT_W-1:0];
          end
        end
        if (!got_free) begin
          slot            = mru_slot;
          r.evicted_valid = 1'b1;
          r.evicted_page  = tbl_page[slot];
        end else begin
          tbl_valid[slot] = 1'b1;
          filled++;
        end
      end else begin
        // table at its limit: the most recently touched frame goes
        slot = mru_slot;
        if (tbl_valid[slot]) begin
          r.evicted_valid = 1'b1;
          r.evicted_page  = tbl_page[slot];
        end else begin
          tbl_valid[slot] = 1'b1;
          filled++;
        end
      end
      tbl_page[slot] = item.page_number;
    end
    mru_slot       = slot;
    r.frame_slot   = slot;
    r.fault_count  = fault_tally;
    r.access_count = access_tally;
    r.run_end      = item.last_access;
    if (item.last_access) clear_table();
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(21, 80);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // One access beat; the prediction is taken at the accepting edge
  task automatic send_access(input logic [PAGE_W-1:0] page, input logic last);
    int gap;
    in_t item;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      access_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.page_number = page;
    item.last_access = last;
    access_valid <= 1'b1;
    access       <= item;
    @(posedge clk);
    while (access_stall) @(posedge clk);
    expected_results.push_back(predict_access(item));
  endtask

  task automatic drain();
    access_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write frames_in_use, then read it back
  task automatic config_frame_limit(input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FRAMES_IN_USE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    frame_limit = data[CFG_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("prdata frames_in_use", prdata, {{(APB_DATA_W-CFG_W){1'b0}}, frame_limit});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_fill_evict();
    sender_gaps  = 1'b1;
    stall_random = 1'b1;
    send_access(16'h0000, 1'b0);
    send_access(16'hFFFF, 1'b0);
    send_access(16'h5555, 1'b0);
    send_access(16'hAAAA, 1'b0);
    for (int k = 1; k <= 12; k++) send_access(PAGE_W'(k), 1'b0);
    send_access(16'hFFFF, 1'b0);  // hit, slot 1 becomes most recent
    send_access(16'h1234, 1'b0);  // full table: replaces slot 1
    send_access(16'h1234, 1'b0);
    drain();
    // limit dropped below the fill level mid-run
    config_frame_limit(32'd2);
    send_access(16'h4321, 1'b0);
    send_access(16'h8000, 1'b1);  // fault that ends the run
    send_access(16'hFFFF, 1'b0);  // fresh run after clear
    drain();
  endtask

  task automatic test_limit_extremes();
    config_frame_limit(32'd0);    // acts as one frame
    send_access(16'h00F0, 1'b0);
    send_access(16'h0F00, 1'b0);
    send_access(16'h0F00, 1'b0);
    send_access(16'h00F0, 1'b1);
    drain();
    config_frame_limit(32'hFFFF_FFFF);  // 31 acts as FRAMES
    send_access(16'h7FFF, 1'b0);
    send_access(16'h7FFF, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    stall_random = 1'b0;
    config_frame_limit(32'd4);
    hold_request++;
    repeat (12) send_access(PAGE_W'($urandom()), 1'b0);
    drain();
    // sender pauses until everything is back
    repeat (5) send_access(PAGE_W'($urandom_range(0, 7)), 1'b0);
    drain();
    repeat (4) send_access(PAGE_W'($urandom_range(0, 7)), 1'b0);
    send_access(PAGE_W'($urandom_range(0, 7)), 1'b1);
    drain();
    stall_random = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0]  limits [9] = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd3, 5'd8, 5'd15, 5'd5};
    logic [PAGE_W-1:0] pool[$];
    logic [PAGE_W-1:0] page;
    logic [31:0]       data;
    int                pool_len;
    for (int p = 0; p < 9; p++) begin
      drain();
      data = {27'd0, limits[p]};
      if (p % 2 == 1) data[31:CFG_W] = 27'($urandom());
      config_frame_limit(data);
      sender_gaps  = (p % 3 != 0);
      stall_random = (p % 4 != 1);
      pool_len = (limits[p] == 0) ? 1 : (limits[p] > FRAMES) ? FRAMES : int'(limits[p]);
      pool_len += $urandom_range(0, 3);
      pool.delete();
      repeat (pool_len) pool.push_back(PAGE_W'($urandom()));
      repeat (78) begin
        if ($urandom_range(0, 99) < 85) page = pool[$urandom_range(0, pool.size() - 1)];
        else page = PAGE_W'($urandom());
        send_access(page, $urandom_range(0, 39) == 0);
      end
    end
    drain();
  endtask

  // Result side stall: random bursts, plus a long hold when asked
  int hold_served = 0;
  int hold_left   = 0;
  int stall_left  = 0;
  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!stall_random) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      result_stall <= ($urandom_range(0, 2) == 0);
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("hit", 32'(result.hit), 32'(want.hit));
        check_field("evicted_valid", 32'(result.evicted_valid), 32'(want.evicted_valid));
        check_field("evicted_page", 32'(result.evicted_page), 32'(want.evicted_page));
        check_field("frame_slot", 32'(result.frame_slot), 32'(want.frame_slot));
        check_field("fault_count", result.fault_count, want.fault_count);
        check_field("access_count", result.access_count, want.access_count);
        check_field("run_end", 32'(result.run_end), 32'(want.run_end));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    access_valid <= 1'b0;
    access       <= '0;
    clear_table();
    frame_limit = FRAMES_IN_USE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_evict();
    test_limit_extremes();
    test_backpressure();
    test_random_traffic();
    drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
